/* rtl/core/amr_storage_frame_counter_unit_defines.svh */
// Assertion macros shared by the frame counter RTL.
`ifndef AMR_STORAGE_FRAME_COUNTER_UNIT_DEFINES_SVH
`define AMR_STORAGE_FRAME_COUNTER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASFC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("asfc same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASFC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("asfc next-cycle check failed");

`endif

/* rtl/core/asfc_pkg.sv */
package asfc_pkg;

	// Tally width of the frame counter
	localparam int COUNT_WIDTH = 32;
	localparam int SEC_W       = COUNT_WIDTH - 5;
	localparam int TALLY_EXT_W = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
	localparam int SEC_EXT_W   = (SEC_W > 27) ? SEC_W : 27;
	localparam int FRAMES_PER_SEC = 50;

	localparam logic [31:0] GOOD_MAX    = 32'hFFFF_FFFF;
	localparam logic [26:0] SECONDS_MAX = 27'h7FF_FFFF;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_WORD_ERR = 2'd1;
	localparam logic [1:0] ST_HDR_ERR  = 2'd2;
	localparam logic [1:0] ST_NO_FRAME = 2'd3;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [3:0] FT_MAX     = 4'd8;

	// Magic words, first byte in the low bits
	localparam logic [47:0] WORD_MONO  = {8'h0A, "R", "M", "A", "!", "#"};
	localparam logic [47:0] WORD_DASH  = {"-", "R", "M", "A", "!", "#"};
	localparam logic [47:0] WORD_UNDER = {"_", "R", "M", "A", "!", "#"};

	typedef struct packed {
		logic [1:0]  status;
		logic        is_wideband;
		logic        is_multichannel;
		logic [3:0]  channel_count;
		logic [4:0]  header_bytes;
		logic [7:0]  toc_byte;
		logic [3:0]  frame_type;
		logic [11:0] bitrate_hundredths;
		logic [5:0]  frame_bytes;
		logic [31:0] good_frames;
		logic [26:0] seconds;
	} asfc_result_t;

	// Compare six received bytes to a word, letters in either case
	function automatic logic word_match(input logic [47:0] got, input logic [47:0] word);
		logic ok;
		logic [7:0] b;
		logic [7:0] e;
		ok = 1'b1;
		for (int k = 0; k < 6; k++) begin
			b = got[8*k +: 8];
			e = word[8*k +: 8];
			if (!((b == e) || (e >= "A" && e <= "Z" && b == e + 8'd32)))
				ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic [5:0] toc_frame_len(input logic wb, input logic [3:0] ft);
		logic [5:0] sz;
		unique case (ft)
			4'd0: sz = wb ? 6'd18 : 6'd13;
			4'd1: sz = wb ? 6'd24 : 6'd14;
			4'd2: sz = wb ? 6'd33 : 6'd16;
			4'd3: sz = wb ? 6'd37 : 6'd18;
			4'd4: sz = wb ? 6'd41 : 6'd20;
			4'd5: sz = wb ? 6'd47 : 6'd21;
			4'd6: sz = wb ? 6'd51 : 6'd27;
			4'd7: sz = wb ? 6'd59 : 6'd32;
			4'd8: sz = wb ? 6'd61 : 6'd6;
			default: sz = 6'd0;
		endcase
		return sz;
	endfunction

	function automatic logic [11:0] bitrate(input logic wb, input logic [3:0] ft);
		logic [11:0] r;
		unique case (ft)
			4'd0: r = wb ? 12'd660  : 12'd475;
			4'd1: r = wb ? 12'd885  : 12'd515;
			4'd2: r = wb ? 12'd1265 : 12'd590;
			4'd3: r = wb ? 12'd1425 : 12'd670;
			4'd4: r = wb ? 12'd1585 : 12'd740;
			4'd5: r = wb ? 12'd1825 : 12'd795;
			4'd6: r = wb ? 12'd1985 : 12'd1020;
			4'd7: r = wb ? 12'd2305 : 12'd1220;
			4'd8: r = wb ? 12'd2385 : 12'd180;
			default: r = 12'd0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/amr_storage_frame_counter_unit.sv */
// AMR storage frame counter. Feed the bytes of one storage file, in order, one byte per
// beat on s_axis, with s_axis_tlast on the final byte. The unit parses the magic header
// (mono or multichannel, narrowband or wideband), locks on the first frame header byte
// with Q set and a valid frame type, then skips frame bodies and counts every header byte
// that equals the reference one, resyncing a byte at a time. Exactly one result word
// leaves on m_axis per file, from the result register, and the unit is then ready for
// the next file. Throughput is one byte per clock: each byte passes an input register and
// one pass of parse and count logic into the parser registers, and the last byte's result
// into the result register. The input keeps flowing while a result waits; it holds only
// when a second last byte arrives before the previous result has been taken. Seconds is
// the frame count over 50, kept exact by a running modulo-50 counter beside the tally.
`include "amr_storage_frame_counter_unit_defines.svh"

module amr_storage_frame_counter_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] is_wideband, [1] is_multichannel, [5:2] channel_count, [10:6] header_bytes,
	// [18:11] toc_byte, [22:19] frame_type, [34:23] bitrate_hundredths,
	// [40:35] frame_bytes, [72:41] good_frames, [99:73] seconds, [103:100] zero
	output logic [103:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser    // [1:0] status
);
	import asfc_pkg::*;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_SEARCH = 3'd1;
	localparam logic [2:0] PH_SKIP   = 3'd2;
	localparam logic [2:0] PH_MATCH  = 3'd3;
	localparam logic [2:0] PH_HALT   = 3'd4;

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       advance;
	logic       proc;

	// Parser state
	logic [2:0]             phase_q, phase_d;
	logic [4:0]             pos_q, pos_d;
	logic [47:0]            magic_q, magic_d, magic_ins;
	logic [4:0]             hlen_q, hlen_d, hlen_w;
	logic                   wb_q, wb_d, wb_w;
	logic [3:0]             chan_q, chan_d;
	logic [7:0]             toc_q, toc_d;
	logic [5:0]             flen_q, flen_d;
	logic [5:0]             skip_q, skip_d;
	logic [COUNT_WIDTH-1:0] tally_q, tally_d;
	logic [5:0]             frac_q, frac_d;
	logic [SEC_W-1:0]       secs_q, secs_d;
	logic [1:0]             err_q, err_d;

	logic [4:0]     hdr_i;
	logic [47:0]    word_sel;
	logic           halt;
	logic [3:0]     ft_in;
	logic [3:0]     ft_out;
	logic [TALLY_EXT_W-1:0] tally_ext;
	logic [SEC_EXT_W-1:0]   secs_ext;

	asfc_result_t res_d, res_q;
	logic         out_valid_q;

	// Stall only a last byte that would overwrite a result not yet taken
	assign advance       = !(valid_s1 && last_s1 && out_valid_q && !m_axis_tready);
	assign proc          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	assign hdr_i = pos_q + 5'd1;
	assign ft_in = byte_s1[6:3];

	// Insert the current byte into the magic word while inside the first six bytes
	always_comb begin
		magic_ins = magic_q;
		if (pos_q < 5'd6)
			magic_ins[{pos_q[2:0], 3'b000} +: 8] = byte_s1;
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		magic_d  = magic_q;
		hlen_d   = hlen_q;
		wb_d     = wb_q;
		chan_d   = chan_q;
		toc_d    = toc_q;
		flen_d   = flen_q;
		skip_d   = skip_q;
		tally_d  = tally_q;
		frac_d   = frac_q;
		secs_d   = secs_q;
		err_d    = err_q;
		hlen_w   = hlen_q;
		wb_w     = wb_q;
		word_sel = WORD_MONO;
		halt     = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				magic_d = magic_ins;
				if (hlen_q == 5'd0) begin
					if (byte_s1 == CH_NEWLINE && pos_q < 5'd15) begin
						// Newline position picks the word to check
						priority if (hdr_i == 5'd6) begin
							word_sel = WORD_MONO;
						end else if (hdr_i == 5'd9 || hdr_i == 5'd15) begin
							word_sel = WORD_DASH;
						end else if (hdr_i == 5'd12) begin
							word_sel = WORD_UNDER;
						end else begin
							err_d = ST_HDR_ERR;
							halt  = 1'b1;
						end
						if (!halt) begin
							if (!word_match(magic_ins, word_sel)) begin
								err_d = ST_WORD_ERR;
								halt  = 1'b1;
							end else begin
								// Multichannel headers carry four more bytes
								hlen_w = (hdr_i >= 5'd12) ? hdr_i + 5'd4 : hdr_i;
								wb_w   = (hdr_i == 5'd9 || hdr_i == 5'd15);
							end
						end
					end else if (pos_q >= 5'd14) begin
						err_d = ST_HDR_ERR;
						halt  = 1'b1;
					end
				end
				if (halt) begin
					phase_d = PH_HALT;
				end else begin
					hlen_d = hlen_w;
					wb_d   = wb_w;
					if (hlen_w != 5'd0 && hdr_i == hlen_w) begin
						if (hlen_w >= 5'd16)
							chan_d = byte_s1[3:0];
						phase_d = PH_SEARCH;
					end
					if (pos_q < 5'd31)
						pos_d = pos_q + 5'd1;
				end
			end
			PH_SEARCH: begin
				// Lock on the first byte with Q set and a known frame type
				if (byte_s1[2] && ft_in <= FT_MAX) begin
					toc_d   = byte_s1;
					flen_d  = toc_frame_len(wb_q, ft_in);
					tally_d = COUNT_WIDTH'(1);
					frac_d  = 6'd1;
					secs_d  = '0;
					skip_d  = toc_frame_len(wb_q, ft_in) - 6'd1;
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_d = (skip_q != 6'd0) ? skip_q - 6'd1 : skip_q;
				if (skip_d == 6'd0)
					phase_d = PH_MATCH;
			end
			PH_MATCH: begin
				if (byte_s1 == toc_q) begin
					if (tally_q != {COUNT_WIDTH{1'b1}}) begin
						tally_d = tally_q + COUNT_WIDTH'(1);
						if (frac_q == 6'(FRAMES_PER_SEC - 1)) begin
							frac_d = 6'd0;
							secs_d = secs_q + SEC_W'(1);
						end else begin
							frac_d = frac_q + 6'd1;
						end
					end
					skip_d  = flen_q - 6'd1;
					phase_d = (skip_d == 6'd0) ? PH_MATCH : PH_SKIP;
				end
			end
			default: begin
				// Halted: drop bytes until the last one
			end
		endcase
	end

	assign ft_out    = (toc_d[6:3] > FT_MAX) ? FT_MAX : toc_d[6:3];
	assign tally_ext = TALLY_EXT_W'(tally_d);
	assign secs_ext  = SEC_EXT_W'(secs_d);

	// Result from the state as it stands after this byte
	always_comb begin
		res_d = '0;
		priority if (err_d != ST_OK) begin
			res_d.status = err_d;
		end else if (phase_d == PH_HEADER) begin
			res_d.status = ST_HDR_ERR;
		end else begin
			res_d.is_wideband     = wb_d;
			res_d.is_multichannel = (hlen_d >= 5'd16);
			res_d.channel_count   = chan_d;
			res_d.header_bytes    = hlen_d;
			if (phase_d == PH_SEARCH) begin
				res_d.status = ST_NO_FRAME;
			end else begin
				res_d.status             = ST_OK;
				res_d.toc_byte           = toc_d;
				res_d.frame_type         = ft_out;
				res_d.bitrate_hundredths = bitrate(wb_d, ft_out);
				res_d.frame_bytes        = flen_d;
				res_d.good_frames        = (tally_ext > TALLY_EXT_W'(GOOD_MAX)) ?
					GOOD_MAX : tally_ext[31:0];
				res_d.seconds            = (secs_ext > SEC_EXT_W'(SECONDS_MAX)) ?
					SECONDS_MAX : secs_ext[26:0];
			end
		end
	end

	// Advance the parser; clear it after the last byte for the next file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			magic_q <= '0;
			hlen_q  <= '0;
			wb_q    <= 1'b0;
			chan_q  <= '0;
			toc_q   <= '0;
			flen_q  <= '0;
			skip_q  <= '0;
			tally_q <= '0;
			frac_q  <= '0;
			secs_q  <= '0;
			err_q   <= ST_OK;
		end else if (proc) begin
			if (last_s1) begin
				phase_q <= PH_HEADER;
				pos_q   <= '0;
				magic_q <= '0;
				hlen_q  <= '0;
				wb_q    <= 1'b0;
				chan_q  <= '0;
				toc_q   <= '0;
				flen_q  <= '0;
				skip_q  <= '0;
				tally_q <= '0;
				frac_q  <= '0;
				secs_q  <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_d;
				pos_q   <= pos_d;
				magic_q <= magic_d;
				hlen_q  <= hlen_d;
				wb_q    <= wb_d;
				chan_q  <= chan_d;
				toc_q   <= toc_d;
				flen_q  <= flen_d;
				skip_q  <= skip_d;
				tally_q <= tally_d;
				frac_q  <= frac_d;
				secs_q  <= secs_d;
				err_q   <= err_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1)
			res_q <= res_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tdata  = {4'b0000, res_q.seconds, res_q.good_frames, res_q.frame_bytes,
		res_q.bitrate_hundredths, res_q.frame_type, res_q.toc_byte, res_q.header_bytes,
		res_q.channel_count, res_q.is_multichannel, res_q.is_wideband};

	`ASFC_ASSERT_SAME(a_skip_nonzero, phase_q == PH_SKIP, skip_q != 6'd0)
	`ASFC_ASSERT_SAME(a_err_halts, err_q != ST_OK, phase_q == PH_HALT)
	`ASFC_ASSERT_SAME(a_ok_has_frames, out_valid_q && res_q.status == ST_OK,
		res_q.good_frames != 32'd0 && res_q.frame_bytes != 6'd0)
	`ASFC_ASSERT_NEXT(a_last_gives_result, proc && last_s1, out_valid_q)

endmodule
